### rtl/core/sv39pm_pkg.sv
// ----------------------------------------------------------------------------
// sv39pm_pkg
// Field widths, entry layout and status codes shared by the page mapper.
// ----------------------------------------------------------------------------
package sv39pm_pkg;

  localparam int VA_W      = 39;
  localparam int PA_W      = 56;
  localparam int SIZE_W    = 21;
  localparam int PERM_W    = 3;
  localparam int PPN_W     = 44;
  localparam int VPN_W     = 9;
  localparam int VPAGE_W   = VA_W - 12;
  localparam int DONE_W    = 9;
  localparam int PAGES_W   = 10;
  localparam int PTE_W     = 54;
  localparam int PPN_LSB   = 10;
  // one mark bit above the pte tells a live entry from one left before its table was taken anew
  localparam int ENTRY_W   = PTE_W + 1;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REMAP    = 2'd1,
    ST_NO_TABLE = 2'd2
  } status_t;

endpackage

### rtl/core/sv39pm_ram.sv
// ----------------------------------------------------------------------------
// sv39pm_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module sv39pm_ram #(
  parameter int WIDTH = 55,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/core/sv39_page_mapper.sv
// ----------------------------------------------------------------------------
// sv39_page_mapper
// Maps a run of 4 KiB pages into an Sv39 page table kept in an internal pool.
//
// A request on the in_ channel names a virtual address, a physical address,
// a byte length and permission bits. For each page the block walks levels 2
// and 1 of the table, takes a new table from the pool where one is missing,
// and writes the leaf entry. One result per request comes out on out_: a
// status and the count of pages mapped. cfg_we/cfg_wdata set the physical
// page number of pool table 0; write it only while the block is idle.
// All table entries sit in one single-port RAM; every level takes a read
// state and an update state (S_RD, then S_EV), for levels 2, 1 and 0.
// Taking a new table costs nothing extra: a per-table mark bit retires
// its old entries. After reset the block clears all NUM_TABLES * 512 RAM
// entries and holds in_tready low meanwhile. The result sits in an output
// register; a new request is taken while it waits, and a finished run
// waits for the register to empty if the receiver stalls.
// ----------------------------------------------------------------------------
module sv39_page_mapper
  import sv39pm_pkg::*;
#(
  parameter int NUM_TABLES = 16,
  parameter int MAX_PAGES  = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [PPN_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // virt_addr[38:0], phys_addr[94:39], byte_size[115:95], perm_flags[118:116]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[1:0], pages_done[10:2]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int TBL_W  = $clog2(NUM_TABLES);
  localparam int NF_W   = $clog2(NUM_TABLES + 1);
  localparam int DEPTH  = NUM_TABLES * 512;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [PAGES_W-1:0] PG_LIM = PAGES_W'((MAX_PAGES < 512) ? MAX_PAGES : 512);

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_RD   = 5'b00100,
    S_EV   = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [PPN_W-1:0]    pool_r;
  logic [NF_W-1:0]     next_free_r;
  logic [NUM_TABLES-1:0] mark_r;
  logic [TBL_W-1:0]    cur_tbl_r;
  logic [1:0]          lvl_r;
  logic [VPAGE_W-1:0]  va_r;
  logic [PPN_W-1:0]    pa_r;
  logic [PERM_W-1:0]   perm_r;
  logic [PAGES_W-1:0]  pages_r;
  logic [PAGES_W-1:0]  done_r;
  status_t             status_r;
  logic [PPN_W-1:0]    ptr_ppn_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic [VPN_W-1:0]    vpn_sel;
  logic                cur_mark;
  logic                ent_live;
  logic [PPN_W-1:0]    ent_off;
  logic                off_ok;
  logic                can_alloc;
  logic [TBL_W-1:0]    fresh_tbl;
  logic [SIZE_W:0]     size_sum;
  logic [PAGES_W-1:0]  pages_raw;
  logic [PAGES_W-1:0]  pages_in;
  logic [PAGES_W-1:0]  done_inc;
  logic                out_load;

  sv39pm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_pte_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (lvl_r)
      2'd2:    vpn_sel = va_r[3*VPN_W-1:2*VPN_W];
      2'd1:    vpn_sel = va_r[2*VPN_W-1:VPN_W];
      default: vpn_sel = va_r[VPN_W-1:0];
    endcase
  end

  assign cur_mark  = mark_r[cur_tbl_r];
  assign ent_live  = ram_rdata[0] && (ram_rdata[ENTRY_W-1] == cur_mark);
  assign ent_off   = ram_rdata[PTE_W-1:PPN_LSB] - pool_r;
  assign off_ok    = ent_off < PPN_W'(NUM_TABLES);
  assign can_alloc = next_free_r < NF_W'(NUM_TABLES);
  assign fresh_tbl = next_free_r[TBL_W-1:0];
  assign done_inc  = done_r + PAGES_W'(1);
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_tready);

  assign size_sum  = {1'b0, in_tdata[115:95]} + (SIZE_W+1)'(4095);
  assign pages_raw = size_sum[SIZE_W:12];
  assign pages_in  = (pages_raw > PG_LIM) ? PG_LIM : pages_raw;

  // ram port: sweep during clear, otherwise the walk address for read and update
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = {cur_tbl_r, vpn_sel};
    ram_wdata = '0;
    if (state_r == S_CLR) begin
      ram_we   = 1'b1;
      ram_addr = clr_cnt_r;
    end else if (state_r == S_EV && !ent_live) begin
      if (lvl_r != 2'd0) begin
        ram_we    = can_alloc;
        // the new table may be the one being written, so its flipped mark applies
        ram_wdata = {cur_mark ^ (cur_tbl_r == fresh_tbl), ptr_ppn_r,
                     (PPN_LSB-1)'(0), 1'b1};
      end else begin
        ram_we    = 1'b1;
        ram_wdata = {cur_mark, pa_r, (PPN_LSB-PERM_W-1)'(0), perm_r, 1'b1};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:   if (clr_cnt_r == ADDR_W'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_tvalid) state_nxt = (pages_in == '0) ? S_FIN : S_RD;
      S_RD:    state_nxt = S_EV;
      S_EV: begin
        if (lvl_r != 2'd0) begin
          if (ent_live ? off_ok : can_alloc) state_nxt = S_RD;
          else state_nxt = S_FIN;
        end else if (ent_live || done_inc == pages_r) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_FIN:   if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      pool_r      <= '0;
      next_free_r <= NF_W'(1);
      mark_r      <= '0;
      cur_tbl_r   <= '0;
      lvl_r       <= 2'd2;
      done_r      <= '0;
      pages_r     <= '0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        pool_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {(OUT_DATA_W-DONE_W-2)'(0), done_r[DONE_W-1:0], status_r};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
        S_IDLE: begin
          if (in_tvalid) begin
            va_r      <= in_tdata[38:12];
            pa_r      <= in_tdata[94:51];
            perm_r    <= in_tdata[118:116];
            pages_r   <= pages_in;
            done_r    <= '0;
            status_r  <= ST_OK;
            cur_tbl_r <= '0;
            lvl_r     <= 2'd2;
          end
        end
        S_RD: ptr_ppn_r <= pool_r + PPN_W'(next_free_r);
        S_EV: begin
          if (lvl_r != 2'd0) begin
            if (ent_live) begin
              if (off_ok) begin
                cur_tbl_r <= ent_off[TBL_W-1:0];
                lvl_r     <= lvl_r - 2'd1;
              end else begin
                status_r <= ST_NO_TABLE;
              end
            end else if (can_alloc) begin
              mark_r[fresh_tbl] <= ~mark_r[fresh_tbl];
              next_free_r       <= next_free_r + NF_W'(1);
              cur_tbl_r         <= fresh_tbl;
              lvl_r             <= lvl_r - 2'd1;
            end else begin
              status_r <= ST_NO_TABLE;
            end
          end else if (ent_live) begin
            status_r <= ST_REMAP;
          end else begin
            done_r    <= done_inc;
            va_r      <= va_r + VPAGE_W'(1);
            pa_r      <= pa_r + PPN_W'(1);
            cur_tbl_r <= '0;
            lvl_r     <= 2'd2;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r >= NF_W'(1) && next_free_r <= NF_W'(NUM_TABLES))
    else $error("table allocator out of range");

  a_tbl_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_tbl_r < TBL_W'(NUM_TABLES) || NUM_TABLES == (1 << TBL_W))
    else $error("walk points outside the pool");

  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_EV || state_r == S_FIN) |-> done_r <= pages_r)
    else $error("mapped more pages than requested");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_FIN))
    else $error("result issued outside completion");

  a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> !ram_we)
    else $error("table write while not walking");

endmodule
